// ===== src/sliding_window_min_path_cost_core_assert.svh =====
// Assertion macros for the sliding window minimum path cost core
`ifndef SLIDING_WINDOW_MIN_PATH_COST_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MIN_PATH_COST_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SWMPC_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window core: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define SWMPC_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window core: next-cycle check failed");

`endif

// ===== src/swmpc_pkg.sv =====
// Shared widths, constants, state type and saturating add for the path cost core
package swmpc_pkg;

  localparam int MAX_WINDOW_DEF = 1024;
  localparam int STEP_W         = 32;
  localparam int COST_W         = 56;
  localparam int CFG_W          = 11;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QCHK,
    ST_FRD,
    ST_FCHK,
    ST_BCHK,
    ST_PUSH
  } state_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [STEP_W-1:0] b);
    logic [COST_W:0] s;
    s = (COST_W+1)'(a) + (COST_W+1)'(b);
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

// ===== src/swmpc_dq_ram.sv =====
// Single-port-write, single-port-read deque memory with registered read data
module swmpc_dq_ram #(
  parameter int DEPTH = swmpc_pkg::MAX_WINDOW_DEF,
  parameter int DW    = $clog2(swmpc_pkg::MAX_WINDOW_DEF) + 1 + swmpc_pkg::COST_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/swmpc_ctrl.sv =====
// Sequencer for the monotonic deque: window query, front expiry, back pops and push
module swmpc_ctrl #(
  parameter int MAX_WINDOW = swmpc_pkg::MAX_WINDOW_DEF,
  localparam int AW        = $clog2(MAX_WINDOW),
  localparam int PW        = AW + 1,
  localparam int DW        = PW + swmpc_pkg::COST_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swmpc_pkg::STEP_W-1:0]  step_cost,
  input  logic                          start_req,
  input  logic                          cfg_we,
  input  logic [swmpc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          out_free,
  output logic                          res_push,
  output logic [swmpc_pkg::COST_W-1:0]  res_cost,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [DW-1:0]                 mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [DW-1:0]                 mem_rdata
);

  import swmpc_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   weff;
  logic [CW-1:0]   stored;
  logic [CW-1:0]   count;
  logic [CW-1:0]   qoff;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [PW-1:0]   pos;
  logic [STEP_W-1:0] cost;
  logic [COST_W-1:0] sum;

  logic [PW-1:0]     rd_pos;
  logic [COST_W-1:0] rd_val;
  logic [PW-1:0]     age;
  logic              q_skip;
  logic              f_drop;
  logic [CW-1:0]     f_count;
  logic              b_pop;
  logic [CW-1:0]     b_count;
  logic              accept;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(MAX_WINDOW - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(MAX_WINDOW - 1) : a - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(MAX_WINDOW)) begin
      s = s - (AW+1)'(MAX_WINDOW);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_window(input logic [CFG_W-1:0] d);
    if (d == '0) begin
      return CW'(1);
    end else if (32'(d) > 32'(MAX_WINDOW)) begin
      return CW'(MAX_WINDOW);
    end else begin
      return CW'(d);
    end
  endfunction

  assign rd_pos  = mem_rdata[DW-1:COST_W];
  assign rd_val  = mem_rdata[COST_W-1:0];
  assign age     = pos - rd_pos;
  assign q_skip  = age > PW'(weff);
  assign f_drop  = (count != '0) && (age == PW'(MAX_WINDOW));
  assign f_count = count - CW'(f_drop);
  assign b_pop   = rd_val >= sum;
  assign b_count = count - 1'b1;
  assign accept  = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (start_req) begin
            state_next = ST_PUSH;
          end else if (stored < weff) begin
            state_next = ST_FRD;
          end else begin
            state_next = ST_QCHK;
          end
        end
      end
      ST_QCHK: state_next = q_skip ? ST_QCHK : ST_FCHK;
      ST_FRD:  state_next = ST_FCHK;
      ST_FCHK: state_next = (f_count == '0) ? ST_PUSH : ST_BCHK;
      ST_BCHK: state_next = (b_pop && (b_count != '0)) ? ST_BCHK : ST_PUSH;
      ST_PUSH: state_next = out_free ? ST_IDLE : ST_PUSH;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = (state == ST_PUSH) && out_free;
    res_push  = (state == ST_PUSH) && out_free;
    res_cost  = sum;
    mem_waddr = tail;
    mem_wdata = {pos, sum};
    case (state)
      ST_IDLE: mem_raddr = ring_add(head, qoff);
      ST_QCHK: mem_raddr = q_skip ? ring_add(head, qoff + 1'b1) : head;
      ST_FRD:  mem_raddr = head;
      ST_FCHK: mem_raddr = ring_dec(tail);
      ST_BCHK: mem_raddr = ring_dec(ring_dec(tail));
      default: mem_raddr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      weff   <= CW'(1);
      stored <= '0;
      count  <= '0;
      qoff   <= '0;
      head   <= '0;
      tail   <= '0;
      pos    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        weff <= clamp_window(cfg_data);
        qoff <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && start_req) begin
            stored <= '0;
            count  <= '0;
            qoff   <= '0;
            head   <= '0;
            tail   <= '0;
            pos    <= '0;
          end
        end
        ST_QCHK: begin
          if (q_skip) begin
            qoff <= qoff + 1'b1;
          end
        end
        ST_FCHK: begin
          if (f_drop) begin
            head  <= ring_inc(head);
            count <= f_count;
            qoff  <= (qoff != '0) ? qoff - 1'b1 : '0;
          end
        end
        ST_BCHK: begin
          if (b_pop) begin
            tail  <= ring_dec(tail);
            count <= b_count;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            tail  <= ring_inc(tail);
            count <= count + 1'b1;
            qoff  <= (qoff > count) ? count : qoff;
            pos   <= pos + 1'b1;
            if (stored != CW'(MAX_WINDOW)) begin
              stored <= stored + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cost <= step_cost;
      sum  <= COST_W'(step_cost);
    end else if ((state == ST_QCHK) && !q_skip) begin
      sum <= sat_add(rd_val, cost);
    end
  end

endmodule

// ===== src/sliding_window_min_path_cost_core.sv =====
// Top level of the sliding window minimum path cost core
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  in       | in_valid / in_stall   | step_cost[31:0], start_req
//  out      | out_valid / out_stall | path_cost[55:0]
//  cfg      | cfg_we                | cfg_data[10:0] (window_length)
//
//  An item with start_req goes straight to the push. Any other item steps through the window
//  query (or a front read), the front expiry check, any back pops and the push; the query repeats
//  per skipped deque entry and the back check per popped entry, and each entry is skipped and
//  popped at most once between window writes. The single read port of the deque memory sets
//  this order. Reset gives window_length 1 and an empty history, with no clearing pass. in_stall
//  is high while an item is in progress; out_stall on a held result stalls the next push.
`include "sliding_window_min_path_cost_core_assert.svh"

module sliding_window_min_path_cost_core #(
  parameter int MAX_WINDOW = swmpc_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swmpc_pkg::STEP_W-1:0]  step_cost,
  input  logic                          start_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swmpc_pkg::COST_W-1:0]  path_cost,
  input  logic                          cfg_we,
  input  logic [swmpc_pkg::CFG_W-1:0]   cfg_data
);

  import swmpc_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int DW = AW + 1 + COST_W;

  logic              out_free;
  logic              res_push;
  logic [COST_W-1:0] res_cost;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DW-1:0]     mem_rdata;

  assign out_free = !out_valid || !out_stall;

  swmpc_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .step_cost (step_cost),
    .start_req (start_req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .res_push  (res_push),
    .res_cost  (res_cost),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  swmpc_dq_ram #(
    .DEPTH (MAX_WINDOW),
    .DW    (DW)
  ) u_dq_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      path_cost <= res_cost;
    end
  end

  `SWMPC_CHECK_NOW(a_push_into_free_slot, res_push, out_free)
  `SWMPC_CHECK_NOW(a_push_only_in_flight, res_push, in_stall)
  `SWMPC_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

// ===== tb/sv/tb_sliding_window_min_path_cost_core.sv =====
// Self-checking testbench for the sliding window minimum path cost core
`timescale 1ns / 100ps

module tb_sliding_window_min_path_cost_core;
  import swmpc_pkg::*;

  localparam int DEPTH        = MAX_WINDOW_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int LONG_ITEMS   = 1060;
  localparam int CALM_ITEMS   = 200;
  localparam int REPORT_LINES = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [STEP_W-1:0] value;
    logic              start;
    logic              typed;
    logic [COST_W-1:0] cost;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [STEP_W-1:0] step_cost = '0;
  logic              start_req = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COST_W-1:0] path_cost;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic              typed_valid = 1'b0;
  logic [COST_W-1:0] typed_cost = '0;
  logic              calm = 1'b0;
  logic              hold_req = 1'b0;
  int                mismatches = 0;

  logic [COST_W-1:0] path_history [DEPTH];
  logic [CFG_W-1:0]  held_count;
  logic [9:0]        next_slot;
  logic [CFG_W-1:0]  window_setting;
  logic [COST_W-1:0] expected_costs [$];

  stim_row_t directed_rows [22] = '{
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, 56'h0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, 56'hFFFF_FFFF},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, 56'h1_FFFF_FFFE},
    '{ROW_ITEM, 32'd5,         1'b1, 1'b1, 56'd5},
    '{ROW_ITEM, 32'd0,         1'b0, 1'b1, 56'd5},
    '{ROW_CFG,  32'd0,         1'b0, 1'b0, 56'h0},
    '{ROW_ITEM, 32'd7,         1'b1, 1'b1, 56'd7},
    '{ROW_ITEM, 32'd3,         1'b0, 1'b1, 56'd10},
    '{ROW_CFG,  32'd3,         1'b0, 1'b0, 56'h0},
    '{ROW_ITEM, 32'd9,         1'b1, 1'b1, 56'd9},
    '{ROW_ITEM, 32'd4,         1'b0, 1'b1, 56'd4},
    '{ROW_ITEM, 32'd6,         1'b0, 1'b1, 56'd6},
    '{ROW_ITEM, 32'd1,         1'b0, 1'b1, 56'd5},
    '{ROW_ITEM, 32'd0,         1'b0, 1'b1, 56'd4},
    '{ROW_CFG,  32'd2047,      1'b0, 1'b0, 56'h0},
    '{ROW_ITEM, 32'd2,         1'b1, 1'b1, 56'd2},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, 56'hFFFF_FFFF},
    '{ROW_ITEM, 32'd0,         1'b0, 1'b1, 56'd0},
    '{ROW_CFG,  32'd1024,      1'b0, 1'b0, 56'h0},
    '{ROW_ITEM, 32'hAAAA_AAAA, 1'b1, 1'b0, 56'h0},
    '{ROW_ITEM, 32'h5555_5555, 1'b0, 1'b0, 56'h0},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b0, 56'h0}
  };

  sliding_window_min_path_cost_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .step_cost (step_cost),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .path_cost (path_cost),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned span_limit(input logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > DEPTH) return DEPTH;
    return setting;
  endfunction

  function automatic logic [COST_W-1:0] predict_path_cost(input logic [STEP_W-1:0] cost,
                                                          input logic start);
    int unsigned       w;
    int unsigned       span;
    int unsigned       j;
    logic [9:0]        slot;
    logic [COST_W-1:0] best;
    logic [COST_W:0]   sum;
    if (start) begin
      held_count = '0;
      next_slot  = '0;
    end
    w    = span_limit(window_setting);
    span = (held_count < w) ? held_count : w;
    best = (held_count < w) ? '0 : COST_MAX;
    slot = next_slot;
    for (j = 0; j < span; j++) begin
      slot = slot - 10'd1;
      if (path_history[slot] < best) best = path_history[slot];
    end
    sum = {1'b0, best} + {{(COST_W + 1 - STEP_W){1'b0}}, cost};
    if (sum[COST_W]) sum = {1'b0, COST_MAX};
    path_history[next_slot] = sum[COST_W-1:0];
    next_slot = next_slot + 10'd1;
    if (held_count < DEPTH) held_count = held_count + 1'b1;
    return sum[COST_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] rand_cost();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 15);
      4, 5:       return $urandom_range(0, 255);
      6:          return $urandom;
      7:          return '0;
      8:          return '1;
      default:    return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
                                 input logic [COST_W-1:0] want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin
    logic [COST_W-1:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_costs.size() == 0) begin
          report_mismatch("path_cost with nothing pending", path_cost, '0);
        end else begin
          want = expected_costs.pop_front();
          if (path_cost !== want) report_mismatch("path_cost", path_cost, want);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_path_cost(step_cost, start_req);
        expected_costs.insert(expected_costs.size(), typed_valid ? typed_cost : want);
      end
    end
  end

  task automatic send_item(input logic [STEP_W-1:0] cost, input logic start,
                           input logic typed, input logic [COST_W-1:0] want);
    in_valid    = 1'b1;
    step_cost   = cost;
    start_req   = start;
    typed_valid = typed;
    typed_cost  = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n           = $urandom_range(1, 19);
      in_valid    = 1'b0;
      typed_valid = 1'b0;
      step_cost   = $urandom;
      start_req   = $urandom_range(0, 1);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_costs.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    in_valid    = 1'b0;
    typed_valid = 1'b0;
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we         = 1'b0;
    cfg_data       = $urandom;
    window_setting = value;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] window, input int count, input bit hold);
    int          sent;
    int          len;
    int          k;
    int unsigned w;
    logic        st;
    logic [STEP_W-1:0] c;
    write_window(window);
    if (hold) hold_req = 1'b1;
    w    = span_limit(window);
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, (3 * w + 4 < 60) ? 3 * w + 4 : 60);
      for (k = 0; k < len; k++) begin
        st = (k == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 19) == 0);
        c  = (k == len - 1 && $urandom_range(0, 7) != 0) ? '0 : rand_cost();
        send_item(c, st, 1'b0, '0);
        sender_gap();
      end
      sent += len;
      if ($urandom_range(0, 24) == 0) begin
        in_valid = 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n         = $urandom_range(1, 19);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int i;
    int k;
    for (i = 0; i < DEPTH; i++) path_history[i] = '0;
    held_count     = '0;
    next_slot      = '0;
    window_setting = 11'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_window(directed_rows[r].value[CFG_W-1:0]);
      end else begin
        send_item(directed_rows[r].value, directed_rows[r].start,
                  directed_rows[r].typed, directed_rows[r].cost);
        sender_gap();
      end
    end

    run_phase(11'd1, $urandom_range(15, 30), 1'b0);
    run_phase(11'd2, $urandom_range(15, 30), 1'b0);
    run_phase(11'($urandom_range(3, 8)), $urandom_range(15, 30), 1'b1);
    run_phase(11'd0, $urandom_range(15, 30), 1'b0);
    run_phase(11'($urandom_range(1, 32)), $urandom_range(15, 30), 1'b0);
    run_phase(11'($urandom_range(0, 2047)), $urandom_range(15, 30), 1'b0);
    run_phase(11'd1024, $urandom_range(15, 30), 1'b0);
    run_phase(11'($urandom_range(9, 64)), $urandom_range(15, 30), 1'b0);

    write_window(11'd2047);
    for (k = 0; k < LONG_ITEMS; k++) begin
      if (k == LONG_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_item(rand_cost(), k == 0, 1'b0, '0);
      sender_gap();
    end

    in_valid    = 1'b0;
    typed_valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_costs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sliding_window_min_path_cost_core.f =====
+incdir+src
src/swmpc_pkg.sv
src/swmpc_dq_ram.sv
src/swmpc_ctrl.sv
src/sliding_window_min_path_cost_core.sv
tb/sv/tb_sliding_window_min_path_cost_core.sv
